// File: rtl/core/mrtf_pkg.sv
// ----------------------------------------------------------------------------
// mrtf_pkg
// Shared types and constants for the multi-rate tick flag generator.
// ----------------------------------------------------------------------------
package mrtf_pkg;

	localparam int MAX_RATES     = 8;
	localparam int NUM_RATES_DEF = 8;
	localparam int OP_W          = 2;
	localparam int SEL_W         = 3;
	localparam int FLAG_W        = 8;
	localparam int COUNT_W       = 32;
	localparam int REM_W         = 10;
	localparam int DIV_W         = REM_W + 1;

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_SET   = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef logic [DIV_W-1:0] div_t;

	// divisor of each rate flag
	localparam div_t RATE_DIV [MAX_RATES] = '{
		11'd1, 11'd10, 11'd20, 11'd50, 11'd100, 11'd200, 11'd500, 11'd1000
	};

endpackage

// File: rtl/core/mrtf_in_if.sv
// ----------------------------------------------------------------------------
// mrtf_in_if
// Request channel: valid/ready handshake with op and rate selector.
// ----------------------------------------------------------------------------
interface mrtf_in_if
	import mrtf_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [SEL_W-1:0] rate_select;

	modport source (output valid, output op, output rate_select, input ready);
	modport sink (input valid, input op, input rate_select, output ready);
endinterface

// File: rtl/core/mrtf_out_if.sv
// ----------------------------------------------------------------------------
// mrtf_out_if
// Result channel: valid/ready handshake with flag vector and tick count.
// ----------------------------------------------------------------------------
interface mrtf_out_if
	import mrtf_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [FLAG_W-1:0]  rate_flags;
	logic [COUNT_W-1:0] tick_count;

	modport source (output valid, output rate_flags, output tick_count, input ready);
	modport sink (input valid, input rate_flags, input tick_count, output ready);
endinterface

// File: rtl/core/multi_rate_tick_flags.sv
// ----------------------------------------------------------------------------
// multi_rate_tick_flags
// Wrapping tick counter with sticky flags for eight fixed tick rates.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per handshake: op (tick, set flag, clear flag)
//   and rate_select. rsp returns exactly one result per request, in order:
//   the flag vector and the tick count after the request took effect.
//   A request is captured in the input register at its handshake; the state
//   and the result register are updated from it together once the result
//   register is empty or being taken, and the result is then shown on rsp.
//   Throughput is one request per cycle: the input register and the result
//   register form a two-stage pipe, and req.ready stays high while the result
//   register is empty or being taken.
//   When rsp.ready is low the result holds, the input register keeps one
//   more request, and req.ready drops until the result is taken.
//   Reset clears the count, the flags and the per-rate remainders; both
//   stages come up empty.
//   Flag i is set on a tick whose new count is a multiple of divisor i
//   (1, 10, 20, 50, 100, 200, 500, 1000); the wrap to zero sets all of them.
// ----------------------------------------------------------------------------
module multi_rate_tick_flags
	import mrtf_pkg::*;
#(
	parameter int NUM_RATES = NUM_RATES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mrtf_in_if.sink   req,
	mrtf_out_if.source rsp
);

	localparam logic [SEL_W:0] NUM_RATES_V = (SEL_W+1)'(NUM_RATES);

	// input stage
	logic             valid_s1;
	op_t              op_s1;
	logic [SEL_W-1:0] sel_s1;

	// state and result
	logic [COUNT_W-1:0] cnt_q;
	logic [FLAG_W-1:0]  flags_q;
	logic [REM_W-1:0]   rem_q [NUM_RATES];
	logic               rsp_valid_q;
	logic [COUNT_W-1:0] rsp_cnt_q;
	logic [FLAG_W-1:0]  rsp_flags_q;

	logic               advance;
	logic               load;
	logic               is_tick;
	logic               wrap;
	logic               sel_ok;
	logic [COUNT_W-1:0] cnt_next;
	logic [FLAG_W-1:0]  flags_next;
	logic [FLAG_W-1:0]  hit;
	logic [REM_W-1:0]   rem_next [NUM_RATES];

	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign load      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1  <= op_t'(req.op);
			sel_s1 <= req.rate_select;
		end
	end

	assign is_tick = (op_s1 == OP_TICK);
	assign wrap    = (cnt_q == {COUNT_W{1'b1}});
	assign sel_ok  = ({1'b0, sel_s1} < NUM_RATES_V);

	// next remainder per rate: restart at the divisor or on count wrap
	for (genvar i = 0; i < FLAG_W; i++) begin : g_rate
		if (i < NUM_RATES) begin : g_act
			logic [DIV_W-1:0] inc;
			assign inc         = {1'b0, rem_q[i]} + DIV_W'(1);
			assign rem_next[i] = (inc >= RATE_DIV[i] || wrap) ? '0 : inc[REM_W-1:0];
			assign hit[i]      = (rem_next[i] == '0);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					rem_q[i] <= '0;
				end else if (load && is_tick) begin
					rem_q[i] <= rem_next[i];
				end
			end
		end else begin : g_off
			assign hit[i] = 1'b0;
		end
	end

	always_comb begin
		cnt_next   = cnt_q;
		flags_next = flags_q;
		case (op_s1)
			OP_TICK: begin
				cnt_next   = cnt_q + COUNT_W'(1);
				flags_next = flags_q | hit;
			end
			OP_SET: begin
				if (sel_ok) flags_next = flags_q | (FLAG_W'(1) << sel_s1);
			end
			OP_CLEAR: begin
				if (sel_ok) flags_next = flags_q & ~(FLAG_W'(1) << sel_s1);
			end
			default: begin
				cnt_next   = cnt_q;
				flags_next = flags_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			flags_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q   <= cnt_next;
				flags_q <= flags_next;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_cnt_q   <= cnt_next;
			rsp_flags_q <= flags_next;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.tick_count = rsp_cnt_q;
	assign rsp.rate_flags = rsp_flags_q;

`ifndef SYNTHESIS
	a_tick_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		load && is_tick |=> cnt_q == $past(cnt_q) + COUNT_W'(1))
		else $error("tick did not advance the count by one");

	a_non_tick_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		load && !is_tick |=> $stable(cnt_q))
		else $error("count changed on a non-tick request");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> rsp_valid_q && rsp_cnt_q == cnt_q && rsp_flags_q == flags_q)
		else $error("result register out of step with state");

	a_unused_flags_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(flags_q >> NUM_RATES) == '0)
		else $error("flag set above the active rates");

	a_unit_rate_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q[0] == '0)
		else $error("divide-by-one remainder not zero");
`endif

endmodule

// File: dv/multi_rate_tick_flags_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_rate_tick_flags_tb
// Self-checking bench for the multi-rate tick flag generator. Requests run
// through a directed opening and then random mixes dominated by ticks. Each
// accepted request updates a cycle-free model of the count, the remainders
// and the sticky flags, and each response is compared against the oldest
// prediction. Both channels idle at random, and the receiver also holds off
// long enough to back up the pipe.
// ----------------------------------------------------------------------------
module multi_rate_tick_flags_tb;
	import mrtf_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_OFF_LEN = 150;
	localparam int PHASE_ITEMS = 470;
	localparam logic [DIV_W-1:0] TICK_DIVISORS [MAX_RATES] = '{
		11'd1, 11'd10, 11'd20, 11'd50, 11'd100, 11'd200, 11'd500, 11'd1000
	};

	typedef struct packed {
		logic [FLAG_W-1:0]  rate_flags;
		logic [COUNT_W-1:0] tick_count;
	} flag_result_t;

	class tick_flag_tracker;
		logic [COUNT_W-1:0] count;
		logic [FLAG_W-1:0]  flags;
		logic [REM_W-1:0]   remainders [MAX_RATES];
		flag_result_t       pending_results[$];
		int                 mismatch_count;

		function new();
			count = '0;
			flags = '0;
			foreach (remainders[i])
				remainders[i] = '0;
			mismatch_count = 0;
		endfunction

		function void note_request(logic [OP_W-1:0] op_bits, logic [SEL_W-1:0] sel);
			logic [REM_W:0] next_rem;
			case (op_bits)
				OP_TICK: begin
					count = count + 1'b1;
					for (int i = 0; i < NUM_RATES_DEF; i++) begin
						next_rem = {1'b0, remainders[i]} + 1'b1;
						// wrap of the count restarts every remainder
						if (next_rem >= TICK_DIVISORS[i] || count == '0)
							next_rem = '0;
						remainders[i] = next_rem[REM_W-1:0];
						if (next_rem == '0)
							flags[i] = 1'b1;
					end
				end
				OP_SET: begin
					if (int'(sel) < NUM_RATES_DEF)
						flags[sel] = 1'b1;
				end
				OP_CLEAR: begin
					if (int'(sel) < NUM_RATES_DEF)
						flags[sel] = 1'b0;
				end
				default: ;
			endcase
			pending_results.push_back('{rate_flags: flags, tick_count: count});
		endfunction

		function void check_response(logic [FLAG_W-1:0] got_flags,
				logic [COUNT_W-1:0] got_count);
			flag_result_t exp;
			if (pending_results.size() == 0) begin
				$error("unexpected response: rate_flags %h tick_count %0d",
					got_flags, got_count);
				mismatch_count++;
				return;
			end
			exp = pending_results.pop_front();
			if (got_flags !== exp.rate_flags) begin
				$error("rate_flags: expected %h, actual %h", exp.rate_flags, got_flags);
				mismatch_count++;
			end
			if (got_count !== exp.tick_count) begin
				$error("tick_count: expected %0d, actual %0d", exp.tick_count, got_count);
				mismatch_count++;
			end
		endfunction

		function int pending_count();
			return pending_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   hold_off_cycles;
	int   quiet_cycles;

	tick_flag_tracker tracker;

	mrtf_in_if  req_if ();
	mrtf_out_if rsp_if ();

	multi_rate_tick_flags i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		tracker = new();
	end

	// sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready)
				tracker.note_request(req_if.op, req_if.rate_select);
			if (rsp_if.valid && rsp_if.ready)
				tracker.check_response(rsp_if.rate_flags, rsp_if.tick_count);
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stalls, or a counted hold-off when asked
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				rsp_if.ready <= 1'b0;
				hold_off_cycles--;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input logic [OP_W-1:0] op_bits,
			input logic [SEL_W-1:0] sel);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			req_if.op <= OP_UNUSED;
			req_if.rate_select <= SEL_W'($urandom_range(7));
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.op <= op_bits;
		req_if.rate_select <= sel;
		do
			@(posedge clk);
		while (!req_if.ready);
		@(negedge clk);
	endtask

	task automatic send_random(input int n);
		int pick;
		logic [OP_W-1:0] op_bits;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 78)
				op_bits = OP_TICK;
			else if (pick < 88)
				op_bits = OP_SET;
			else if (pick < 96)
				op_bits = OP_CLEAR;
			else
				op_bits = OP_UNUSED;
			send_request(op_bits, SEL_W'($urandom_range(7)));
		end
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (tracker.pending_count() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.op = OP_TICK;
		req_if.rate_select = '0;
		send_idle_pct = 21;
		recv_idle_pct = 77;
		hold_off_cycles = 0;
		quiet_cycles = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: first ticks, every flag set and cleared, unused op
		send_request(OP_TICK, 3'd7);
		send_request(OP_TICK, 3'd0);
		for (int i = 0; i < MAX_RATES; i++)
			send_request(OP_SET, SEL_W'(i));
		send_request(OP_UNUSED, 3'd7);
		for (int i = MAX_RATES - 1; i >= 0; i--)
			send_request(OP_CLEAR, SEL_W'(i));
		send_request(OP_UNUSED, 3'd0);
		send_request(OP_CLEAR, 3'd0);
		send_request(OP_TICK, 3'd5);
		send_request(OP_SET, 3'd7);
		send_request(OP_TICK, 3'd2);

		send_random(PHASE_ITEMS / 2);
		// long receiver hold-off while requests keep coming
		hold_off_cycles = HOLD_OFF_LEN;
		send_random(PHASE_ITEMS / 2);
		wait_drained();

		send_idle_pct = 77;
		recv_idle_pct = 21;
		send_random(PHASE_ITEMS);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(PHASE_ITEMS);
		wait_drained();
		repeat (10) @(negedge clk);

		if (tracker.mismatch_count == 0 && tracker.pending_count() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
